>>> hw/rtl/hmq_pkg.sv
`default_nettype none

package hmq_pkg;

  // Operation codes of an item
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Item fields
  typedef struct packed {
    logic        opcode;
    logic [15:0] entry_key;
    logic [15:0] entry_tag;
  } hmq_in_t;

  // Result fields
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_key;
    logic [15:0] out_tag;
    logic [7:0]  occupancy;
  } hmq_out_t;

  // Finished operation handed from the sift engine to the result stage
  typedef struct packed {
    logic     valid;
    hmq_out_t res;
  } hmq_fin_t;

  // Sift engine states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_UP_PUT,
    S_RM_LOAD,
    S_DN_CMP
  } hmq_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/hmq_ram.sv
`default_nettype none

module hmq_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read two with registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> hw/rtl/hmq_sift.sv
`default_nettype none

module hmq_sift #(
  parameter int CAPACITY  = 128,
  parameter int KEY_WIDTH = 16,
  parameter int TAG_WIDTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire hmq_pkg::hmq_in_t request,
  output logic                 busy,
  output hmq_pkg::hmq_fin_t    fin
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = IW + 2;
  localparam int EW = KEY_WIDTH + TAG_WIDTH;

  hmq_pkg::hmq_state_t state, state_next;

  logic [CW-1:0]        count, count_next;
  logic [IW-1:0]        idx;
  logic [KEY_WIDTH-1:0] cur_key;
  logic [TAG_WIDTH-1:0] cur_tag;
  logic [KEY_WIDTH-1:0] res_key;
  logic [TAG_WIDTH-1:0] res_tag;

  // Memory ports
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [IW-1:0] raddr_a, raddr_b;
  logic [EW-1:0] rdata_a, rdata_b;

  logic [KEY_WIDTH-1:0] a_key, b_key, new_key;
  logic [TAG_WIDTH-1:0] a_tag, b_tag, new_tag;

  logic          accept, is_full, is_empty;
  logic [IW-1:0] idx_parent, count_parent, idx_last;
  logic [LW-1:0] left, right, count_wide;
  logic          left_ok, right_ok, pick_left, pick_right, up_move, parent_root;
  logic [KEY_WIDTH-1:0] best_key;
  logic [IW-1:0] best_idx;

  hmq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Split read entries and the incoming entry
  assign a_key   = rdata_a[EW-1:TAG_WIDTH];
  assign a_tag   = rdata_a[TAG_WIDTH-1:0];
  assign b_key   = rdata_b[EW-1:TAG_WIDTH];
  assign b_tag   = rdata_b[TAG_WIDTH-1:0];
  assign new_key = KEY_WIDTH'(request.entry_key);
  assign new_tag = TAG_WIDTH'(request.entry_tag);

  assign busy     = (state != hmq_pkg::S_IDLE);
  assign accept   = start && (state == hmq_pkg::S_IDLE);
  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);

  // Tree navigation
  assign idx_parent   = (idx - IW'(1)) >> 1;
  assign count_parent = (IW'(count) - IW'(1)) >> 1;
  assign idx_last     = IW'(count - CW'(1));
  assign parent_root  = (idx_parent == '0);
  assign left         = {1'b0, idx, 1'b1};
  assign right        = left + LW'(1);
  assign count_wide   = LW'(count);

  // Sift-up decision: parent strictly smaller moves down
  assign up_move = (a_key < cur_key);

  // Sift-down decision: left wins ties, right only on strictly greater key
  assign left_ok    = (left < count_wide);
  assign right_ok   = (right < count_wide);
  assign pick_left  = left_ok && (a_key > cur_key);
  assign best_key   = pick_left ? a_key : cur_key;
  assign pick_right = right_ok && (b_key > best_key);
  assign best_idx   = pick_right ? IW'(right) : IW'(left);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      hmq_pkg::S_IDLE: begin
        if (accept) begin
          if (request.opcode == hmq_pkg::OP_INSERT) begin
            if (!is_full && !is_empty) begin
              state_next = hmq_pkg::S_UP_CMP;
            end
          end else if (!is_empty) begin
            state_next = hmq_pkg::S_RM_LOAD;
          end
        end
      end
      hmq_pkg::S_UP_CMP: begin
        if (!up_move) begin
          state_next = hmq_pkg::S_IDLE;
        end else if (parent_root) begin
          state_next = hmq_pkg::S_UP_PUT;
        end
      end
      hmq_pkg::S_UP_PUT: begin
        state_next = hmq_pkg::S_IDLE;
      end
      hmq_pkg::S_RM_LOAD: begin
        if (count == '0) begin
          state_next = hmq_pkg::S_IDLE;
        end else begin
          state_next = hmq_pkg::S_DN_CMP;
        end
      end
      hmq_pkg::S_DN_CMP: begin
        if (!pick_left && !pick_right) begin
          state_next = hmq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = hmq_pkg::S_IDLE;
      end
    endcase
  end

  // Memory control and finished-item outputs
  always_comb begin
    we         = 1'b0;
    waddr      = idx;
    wdata      = {cur_key, cur_tag};
    raddr_a    = '0;
    raddr_b    = '0;
    count_next = count;
    fin        = '0;
    case (state)
      hmq_pkg::S_IDLE: begin
        raddr_a = count_parent;
        raddr_b = idx_last;
        if (accept) begin
          if (request.opcode == hmq_pkg::OP_INSERT) begin
            if (is_full) begin
              fin.valid      = 1'b1;
              fin.res.status = hmq_pkg::STATUS_FULL;
            end else begin
              count_next = count + CW'(1);
              if (is_empty) begin
                we             = 1'b1;
                waddr          = '0;
                wdata          = {new_key, new_tag};
                fin.valid      = 1'b1;
                fin.res.status = hmq_pkg::STATUS_OK;
              end
            end
          end else if (is_empty) begin
            fin.valid      = 1'b1;
            fin.res.status = hmq_pkg::STATUS_EMPTY;
          end else begin
            raddr_a    = '0;
            count_next = count - CW'(1);
          end
        end
      end
      hmq_pkg::S_UP_CMP: begin
        raddr_a = (idx_parent - IW'(1)) >> 1;
        we      = 1'b1;
        if (up_move) begin
          wdata = rdata_a;
        end else begin
          fin.valid      = 1'b1;
          fin.res.status = hmq_pkg::STATUS_OK;
        end
      end
      hmq_pkg::S_UP_PUT: begin
        we             = 1'b1;
        fin.valid      = 1'b1;
        fin.res.status = hmq_pkg::STATUS_OK;
      end
      hmq_pkg::S_RM_LOAD: begin
        raddr_a = IW'(1);
        raddr_b = IW'(2);
        if (count == '0) begin
          fin.valid       = 1'b1;
          fin.res.status  = hmq_pkg::STATUS_OK;
          fin.res.out_key = 16'(a_key);
          fin.res.out_tag = 16'(a_tag);
        end
      end
      hmq_pkg::S_DN_CMP: begin
        raddr_a = IW'({best_idx, 1'b1});
        raddr_b = IW'({best_idx, 1'b1} + (IW + 1)'(1));
        we      = 1'b1;
        if (pick_right) begin
          wdata = rdata_b;
        end else if (pick_left) begin
          wdata = rdata_a;
        end else begin
          fin.valid       = 1'b1;
          fin.res.status  = hmq_pkg::STATUS_OK;
          fin.res.out_key = 16'(res_key);
          fin.res.out_tag = 16'(res_tag);
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
    fin.res.occupancy = 8'(count_next);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hmq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Moving entry and its slot
  always_ff @(posedge clk) begin
    case (state)
      hmq_pkg::S_IDLE: begin
        idx     <= IW'(count);
        cur_key <= new_key;
        cur_tag <= new_tag;
      end
      hmq_pkg::S_UP_CMP: begin
        idx <= idx_parent;
      end
      hmq_pkg::S_RM_LOAD: begin
        idx     <= '0;
        cur_key <= b_key;
        cur_tag <= b_tag;
        res_key <= a_key;
        res_tag <= a_tag;
      end
      hmq_pkg::S_DN_CMP: begin
        idx <= best_idx;
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/binary_max_heap_queue_top.sv
`default_nettype none

// Binary max-heap priority queue. Each item is an insert (opcode 0) or a
// remove of the highest-key entry (opcode 1); the heap lives in one
// two-read, one-write synchronous memory. An item is taken when start is
// high and busy is low; its one result appears on result with done high
// for exactly one cycle, and the receiver cannot stall it. Timing is set by
// the sift loop, one memory read, compare and write per tree level. An
// insert climbs from the new slot, moving each smaller parent down; a remove
// first loads the root and the last entry, then descends level by level (a
// remove of the only entry ends after the load). An insert into an empty
// heap, a rejected insert and an empty remove finish in the accepting cycle.
// done is registered from the finishing cycle (for those short cases, it
// comes in the cycle after acceptance), and the next item may start then.
module binary_max_heap_queue_top #(
  parameter int CAPACITY  = 128,
  parameter int KEY_WIDTH = 16,
  parameter int TAG_WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire hmq_pkg::hmq_in_t request,
  output logic                  busy,
  output logic                  done,
  output hmq_pkg::hmq_out_t     result
);

  hmq_pkg::hmq_fin_t fin;

  hmq_sift #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_sift (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .fin     (fin)
  );

  // Strobe each finished item for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
  end

  // Hold the result fields of the last finished item
  always_ff @(posedge clk) begin
    if (fin.valid) begin
      result <= fin.res;
    end
  end

endmodule

`default_nettype wire
